/* rtl/bgc_pkg.sv */
// Shared types and constants for the button gesture classifier.
package bgc_pkg;

  // Buttons carried by the item ports
  localparam int unsigned PORT_BUTTONS = 2;

  // Configuration register fields and indexes
  localparam int unsigned CFG_BITS  = 16;
  localparam int unsigned ADDR_BITS = 4;

  localparam logic [1:0] REG_DCW  = 2'd0;
  localparam logic [1:0] REG_PUSH = 2'd1;
  localparam logic [1:0] REG_IDLE = 2'd2;

  localparam logic [CFG_BITS-1:0] DCW_RESET  = 16'd500;
  localparam logic [CFG_BITS-1:0] PUSH_RESET = 16'd750;
  localparam logic [CFG_BITS-1:0] IDLE_RESET = 16'd65535;

  // Event codes: zero is a wakeup, the down bit wins over the up bit
  localparam logic [1:0] EV_WAKE     = 2'b00;
  localparam int unsigned EV_DOWN_BIT = 0;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_CLICK  = 2'd1,
    GEST_DOUBLE = 2'd2,
    GEST_PUSH   = 2'd3
  } gesture_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] dcw;
    logic [CFG_BITS-1:0] push;
    logic [CFG_BITS-1:0] idle;
  } cfg_t;

endpackage

/* rtl/bgc_lane.sv */
// Per-button gesture state and classification logic.
module bgc_lane #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  logic [1:0]                     code,
  input  logic [TIME_BITS-1:0]           now,
  input  bgc_pkg::cfg_t                  cfg,
  output bgc_pkg::gesture_t              gesture,
  output logic [bgc_pkg::CFG_BITS-1:0]   wt
);

  logic                          held_r, held_nxt;
  logic [TIME_BITS-1:0]          stamp_r, stamp_nxt;
  logic [TIME_BITS-1:0]          delta;
  logic [bgc_pkg::CFG_BITS-1:0]  delta_lo;
  logic                          hi_nz;
  logic                          pending;
  logic                          ge_push, ge_dcw, le_dcw;

  // Elapsed ticks since the pending press, modulo the time width
  assign delta    = now - stamp_r;
  assign delta_lo = delta[bgc_pkg::CFG_BITS-1:0];
  assign pending  = (stamp_r != '0);

  generate
    if (TIME_BITS > bgc_pkg::CFG_BITS) begin : g_hi
      assign hi_nz = |delta[TIME_BITS-1:bgc_pkg::CFG_BITS];
    end else begin : g_nohi
      assign hi_nz = 1'b0;
    end
  endgenerate

  assign ge_push = hi_nz | (delta_lo >= cfg.push);
  assign ge_dcw  = hi_nz | (delta_lo >= cfg.dcw);
  assign le_dcw  = !hi_nz & (delta_lo <= cfg.dcw);

  // Classification and next state
  always_comb begin
    gesture   = bgc_pkg::GEST_NONE;
    wt        = cfg.idle;
    stamp_nxt = stamp_r;
    held_nxt  = held_r;
    if (code == bgc_pkg::EV_WAKE) begin
      if (pending) begin
        if (held_r) begin
          if (ge_push) begin
            gesture   = bgc_pkg::GEST_PUSH;
            stamp_nxt = '0;
          end else begin
            wt = cfg.push - delta_lo;
          end
        end else begin
          if (ge_dcw) begin
            gesture   = bgc_pkg::GEST_CLICK;
            stamp_nxt = '0;
          end else begin
            wt = cfg.dcw - delta_lo;
          end
        end
      end
    end else if (code[bgc_pkg::EV_DOWN_BIT]) begin
      if (pending && le_dcw) begin
        gesture   = bgc_pkg::GEST_DOUBLE;
        stamp_nxt = '0;
      end else begin
        stamp_nxt = now;
        wt        = cfg.push;
      end
      held_nxt = 1'b1;
    end else begin
      // release: late one is a push, early one waits out the window
      if (pending) begin
        if (!ge_push) begin
          wt = ge_dcw ? '0 : (cfg.dcw - delta_lo);
        end else begin
          gesture   = bgc_pkg::GEST_PUSH;
          stamp_nxt = '0;
        end
      end
      held_nxt = 1'b0;
    end
  end

  // State update on each transfer into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      stamp_r <= '0;
    end else if (fire) begin
      held_r  <= held_nxt;
      stamp_r <= stamp_nxt;
    end
  end

  a_gesture_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (gesture != bgc_pkg::GEST_NONE) |=> (stamp_r == '0))
    else $error("stamp not cleared after gesture");

  a_down_sets_held: assert property (@(posedge clk) disable iff (!rst_n)
    fire && code[bgc_pkg::EV_DOWN_BIT] |=> held_r)
    else $error("held flag not set after press");

  a_double_on_press: assert property (@(posedge clk) disable iff (!rst_n)
    (gesture == bgc_pkg::GEST_DOUBLE) |-> code[bgc_pkg::EV_DOWN_BIT] && pending)
    else $error("double click without press and pending stamp");

endmodule

/* rtl/button_gesture_classifier_unit.sv */
// Button gesture classifier top level: item channels, APB registers, result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one 2-bit event code per button
//   and the current tick count. Each accepted item yields exactly one result
//   on the output channel (out_valid/out_ready): a gesture code per button and
//   the smallest wait, in ticks, until the next wakeup item is needed.
//   An accepted item waits in the input register until the result register is
//   free, then the per-button logic writes the result register and the button
//   state at the same edge. Throughput is one item per cycle while the receiver
//   is ready; the input register accepts a new item while a result waits to be taken.
//   When the receiver stalls, the result register holds and the input register
//   fills, after which in_ready drops until the result is taken.
//   Reset (rst_n low, synchronous) empties both registers, marks all buttons up
//   with nothing pending and restores the register defaults (window 500, push
//   750, idle wait 65535). Registers sit at byte addresses 0, 4 and 8; the user
//   must write them only while no item is in flight, the block does not enforce it.
module button_gesture_classifier_unit #(
  parameter int unsigned TIME_BITS    = 32,
  parameter int unsigned BUTTON_COUNT = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_first_event,
  input  logic [1:0]                        in_second_event,
  input  logic [31:0]                       in_now_ticks,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_first_gesture,
  output logic [1:0]                        out_second_gesture,
  output logic [15:0]                       out_next_wait,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bgc_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int unsigned CB = bgc_pkg::CFG_BITS;

  bgc_pkg::cfg_t            cfg_r;
  logic                     cfg_wr;
  logic [1:0]               cfg_idx;

  logic                     in_valid_r;
  logic [1:0]               ev_r [bgc_pkg::PORT_BUTTONS];
  logic [TIME_BITS-1:0]     now_r, now_nxt;

  logic                     advance;
  logic                     in_xfer;

  bgc_pkg::gesture_t        gest [bgc_pkg::PORT_BUTTONS];
  logic [CB-1:0]            wt   [bgc_pkg::PORT_BUTTONS];
  logic [CB-1:0]            min_wt;

  logic                     out_valid_r;
  bgc_pkg::gesture_t        out_first_r, out_second_r;
  logic [CB-1:0]            out_wait_r;

  // Register port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[bgc_pkg::ADDR_BITS-1:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dcw  <= bgc_pkg::DCW_RESET;
      cfg_r.push <= bgc_pkg::PUSH_RESET;
      cfg_r.idle <= bgc_pkg::IDLE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bgc_pkg::REG_DCW:  cfg_r.dcw  <= pwdata[CB-1:0];
        bgc_pkg::REG_PUSH: cfg_r.push <= pwdata[CB-1:0];
        bgc_pkg::REG_IDLE: cfg_r.idle <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      bgc_pkg::REG_DCW:  prdata[CB-1:0] = cfg_r.dcw;
      bgc_pkg::REG_PUSH: prdata[CB-1:0] = cfg_r.push;
      bgc_pkg::REG_IDLE: prdata[CB-1:0] = cfg_r.idle;
      default:           prdata = '0;
    endcase
  end

  // Tick count resized to the internal time width
  generate
    if (TIME_BITS > 32) begin : g_now_wide
      assign now_nxt = {{(TIME_BITS-32){1'b0}}, in_now_ticks};
    end else if (TIME_BITS == 32) begin : g_now_eq
      assign now_nxt = in_now_ticks;
    end else begin : g_now_narrow
      assign now_nxt = in_now_ticks[TIME_BITS-1:0];
    end
  endgenerate

  // Handshake: the item in the input register moves on when the result slot frees
  assign advance  = in_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~in_valid_r | advance;
  assign in_xfer  = in_valid & in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ev_r[0] <= in_first_event;
      ev_r[1] <= in_second_event;
      now_r   <= now_nxt;
    end
  end

  // Per-button lanes; buttons past BUTTON_COUNT are not tracked
  for (genvar b = 0; b < bgc_pkg::PORT_BUTTONS; b++) begin : g_btn
    if (b < BUTTON_COUNT) begin : g_on
      bgc_lane #(
        .TIME_BITS (TIME_BITS)
      ) u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .code    (ev_r[b]),
        .now     (now_r),
        .cfg     (cfg_r),
        .gesture (gest[b]),
        .wt      (wt[b])
      );
    end else begin : g_off
      assign gest[b] = bgc_pkg::GEST_NONE;
      assign wt[b]   = cfg_r.idle;
    end
  end

  assign min_wt = (wt[0] <= wt[1]) ? wt[0] : wt[1];

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_first_r  <= gest[0];
      out_second_r <= gest[1];
      out_wait_r   <= min_wt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_first_gesture  = out_first_r;
  assign out_second_gesture = out_second_r;
  assign out_next_wait      = out_wait_r;

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ready)
    else $error("input register empty but not ready");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_ready |-> !in_ready && !advance)
    else $error("item moved while result stalled");

  a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result missing after advance");

  a_cfg_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (cfg_r.dcw == bgc_pkg::DCW_RESET) &&
                      (cfg_r.push == bgc_pkg::PUSH_RESET) &&
                      (cfg_r.idle == bgc_pkg::IDLE_RESET))
    else $error("register defaults wrong after reset");

endmodule

/* tb/sv/tb_button_gesture_classifier_unit.sv */
// Self-checking testbench for the two-button gesture classifier unit.
module tb_button_gesture_classifier_unit;

  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 195;
  localparam int unsigned LONG_HOLD       = 200;
  localparam int unsigned QUIET_LIMIT     = 3000;
  localparam int unsigned TAIL_CYCLES     = 6;

  // Event codes and gesture codes taken from the package
  localparam logic [1:0]  EV_WAKE     = bgc_pkg::EV_WAKE;
  localparam int unsigned EV_DOWN_BIT = bgc_pkg::EV_DOWN_BIT;
  localparam bgc_pkg::gesture_t GEST_NONE   = bgc_pkg::GEST_NONE;
  localparam bgc_pkg::gesture_t GEST_CLICK  = bgc_pkg::GEST_CLICK;
  localparam bgc_pkg::gesture_t GEST_DOUBLE = bgc_pkg::GEST_DOUBLE;
  localparam bgc_pkg::gesture_t GEST_PUSH   = bgc_pkg::GEST_PUSH;

  // Event codes beyond the wakeup
  localparam logic [1:0] EV_DOWN = 2'b01;
  localparam logic [1:0] EV_UP   = 2'b10;
  localparam logic [1:0] EV_BOTH = 2'b11;

  typedef struct packed {
    bgc_pkg::gesture_t first_g;
    bgc_pkg::gesture_t second_g;
    logic [15:0]       next_wait;
  } gest_result_t;

  typedef struct {
    logic [1:0]        first_ev;
    logic [1:0]        second_ev;
    logic [31:0]       now;
    bit                has_exp;
    bgc_pkg::gesture_t first_g;
    bgc_pkg::gesture_t second_g;
    logic [15:0]       next_wait;
  } dir_row_t;

  typedef struct {
    bit           has_exp;
    gest_result_t res;
  } pinned_t;

  // Clock, reset and DUT ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_first_event = EV_WAKE;
  logic [1:0]  in_second_event = EV_WAKE;
  logic [31:0] in_now_ticks = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_first_gesture;
  logic [1:0]  out_second_gesture;
  logic [15:0] out_next_wait;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [bgc_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of registers and per-button state
  logic [15:0] win_ticks  = bgc_pkg::DCW_RESET;
  logic [15:0] hold_ticks = bgc_pkg::PUSH_RESET;
  logic [15:0] idle_ticks = bgc_pkg::IDLE_RESET;
  logic        btn_held [2] = '{1'b0, 1'b0};
  logic [31:0] btn_stamp[2] = '{32'd0, 32'd0};

  gest_result_t pending_results[$];
  pinned_t      pinned_q[$];
  dir_row_t     dir_rows[$];

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned fail_cnt     = 0;
  int unsigned quiet_cycles = 0;
  bit          long_hold_req = 1'b0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  bit          gen_down[2] = '{1'b0, 1'b0};
  logic [31:0] tick_now = '0;

  always #5 clk = ~clk;

  button_gesture_classifier_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_first_event     (in_first_event),
    .in_second_event    (in_second_event),
    .in_now_ticks       (in_now_ticks),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_first_gesture  (out_first_gesture),
    .out_second_gesture (out_second_gesture),
    .out_next_wait      (out_next_wait),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // One button: updates its state and returns the gesture and its wait
  function automatic bgc_pkg::gesture_t classify_button(input int b, input logic [1:0] code,
                                                        input logic [31:0] now,
                                                        output logic [15:0] btn_wait);
    logic [31:0]       stamp;
    logic [31:0]       delta;
    bgc_pkg::gesture_t g;
    stamp    = btn_stamp[b];
    delta    = now - stamp;
    g        = GEST_NONE;
    btn_wait = idle_ticks;
    if (code == EV_WAKE) begin
      if (stamp != 0) begin
        if (btn_held[b]) begin
          if (delta >= hold_ticks) begin
            g = GEST_PUSH;
            btn_stamp[b] = '0;
          end else begin
            btn_wait = hold_ticks - delta[15:0];
          end
        end else if (delta >= win_ticks) begin
          g = GEST_CLICK;
          btn_stamp[b] = '0;
        end else begin
          btn_wait = win_ticks - delta[15:0];
        end
      end
    end else if (code[EV_DOWN_BIT]) begin
      // down wins when both bits are set
      if (stamp != 0 && delta <= win_ticks) begin
        g = GEST_DOUBLE;
        btn_stamp[b] = '0;
      end else begin
        btn_stamp[b] = now;
        btn_wait = hold_ticks;
      end
      btn_held[b] = 1'b1;
    end else begin
      // release: window wait saturates at zero once passed
      if (stamp != 0) begin
        if (delta < hold_ticks) begin
          btn_wait = (delta >= win_ticks) ? 16'd0 : win_ticks - delta[15:0];
        end else begin
          g = GEST_PUSH;
          btn_stamp[b] = '0;
        end
      end
      btn_held[b] = 1'b0;
    end
    return g;
  endfunction

  function automatic gest_result_t classify_item(input logic [1:0] e1, input logic [1:0] e2,
                                                 input logic [31:0] now);
    gest_result_t r;
    logic [15:0]  w1;
    logic [15:0]  w2;
    r.first_g   = classify_button(0, e1, now, w1);
    r.second_g  = classify_button(1, e2, now, w2);
    r.next_wait = (w1 <= w2) ? w1 : w2;
    return r;
  endfunction

  // Mostly well-formed press/release sequences, some noise
  function automatic logic [1:0] pick_event(input int b);
    int unsigned r;
    logic [1:0]  ev;
    r = $urandom_range(0, 99);
    if (r < 55) ev = EV_WAKE;
    else if (r < 88) ev = gen_down[b] ? EV_UP : EV_DOWN;
    else ev = 2'($urandom_range(1, 3));
    if (ev[EV_DOWN_BIT]) gen_down[b] = 1'b1;
    else if (ev != EV_WAKE) gen_down[b] = 1'b0;
    return ev;
  endfunction

  // Tick stamps scaled to the current windows, with boundary hits, wraps and jumps
  function automatic logic [31:0] next_tick();
    int unsigned span;
    int unsigned r;
    int          b;
    logic [31:0] t;
    span = (win_ticks > hold_ticks) ? win_ticks : hold_ticks;
    if (span == 0) span = 1;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      t = tick_now + $urandom_range(0, span + span / 2);
    end else if (r < 70) begin
      t = tick_now + $urandom_range(0, span / 4 + 1);
    end else if (r < 85) begin
      b = $urandom_range(0, 1);
      t = btn_stamp[b] + ($urandom_range(0, 1) ? win_ticks : hold_ticks)
          + $urandom_range(0, 2) - 1;
    end else if (r < 95) begin
      t = $urandom();
    end else if (r < 98) begin
      t = '0;
    end else begin
      t = 32'hFFFF_FFFF - $urandom_range(0, span);
    end
    tick_now = t;
    return t;
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(input logic [1:0] e1, input logic [1:0] e2, input logic [31:0] now,
                           input bit has_exp, input gest_result_t pinned);
    int unsigned gap;
    pinned_q.push_back('{has_exp, pinned});
    in_valid        <= 1'b1;
    in_first_event  <= e1;
    in_second_event <= e2;
    in_now_ticks    <= now;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // APB write: setup, then access; register written at the access edge
  task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bgc_pkg::ADDR_BITS'({idx, 2'b00});
    pwdata  <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      bgc_pkg::REG_DCW:  win_ticks  = val;
      bgc_pkg::REG_PUSH: hold_ticks = val;
      bgc_pkg::REG_IDLE: idle_ticks = val;
      default: ;
    endcase
  endtask

  task automatic reg_check(input logic [1:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= bgc_pkg::ADDR_BITS'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== val) begin
      fail_cnt++;
      $display("%0t: register %0d read expected %0d actual %0d", $time, idx, val, prdata[15:0]);
    end
  endtask

  // Register settings per phase: defaults, extremes, zero, mixed and random
  task automatic apply_setting(input int p);
    logic [15:0] w;
    logic [15:0] pu;
    logic [15:0] id;
    case (p)
      0: begin w = bgc_pkg::DCW_RESET; pu = bgc_pkg::PUSH_RESET; id = bgc_pkg::IDLE_RESET; end
      1: begin w = 16'd1;     pu = 16'd1;      id = 16'd1;      end
      2: begin w = 16'hFFFF;  pu = 16'hFFFF;   id = 16'hFFFF;   end
      3: begin w = 16'd0;     pu = 16'd0;      id = 16'd0;      end
      4: begin w = 16'd20;    pu = 16'd60;     id = 16'd1;      end
      5: begin
        w  = 16'($urandom_range(1, 65535));
        pu = 16'($urandom_range(1, 65535));
        id = 16'($urandom_range(1, 65535));
      end
      6: begin
        w  = 16'($urandom_range(1, 3000));
        pu = 16'($urandom_range(1, 3000));
        id = 16'($urandom_range(1, 3000));
      end
      default: begin w = 16'd400; pu = 16'd100; id = 16'd2000; end
    endcase
    reg_write(bgc_pkg::REG_DCW, w);
    reg_write(bgc_pkg::REG_PUSH, pu);
    reg_write(bgc_pkg::REG_IDLE, id);
    reg_check(bgc_pkg::REG_DCW, w);
    reg_check(bgc_pkg::REG_PUSH, pu);
    reg_check(bgc_pkg::REG_IDLE, id);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Input transfers feed the predictor; output transfers are checked in order
  always @(posedge clk) begin : result_check
    pinned_t      pin;
    gest_result_t pred;
    gest_result_t exp_r;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pin = '{1'b0, '0};
        if (pinned_q.size() != 0) pin = pinned_q.pop_front();
        pred = classify_item(in_first_event, in_second_event, in_now_ticks);
        pending_results.push_back(pin.has_exp ? pin.res : pred);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          fail_cnt++;
          $display("%0t: result expected none actual (%0d %0d %0d)", $time,
                   out_first_gesture, out_second_gesture, out_next_wait);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_first_gesture !== exp_r.first_g) begin
            fail_cnt++;
            $display("%0t: first_gesture expected %0d actual %0d", $time,
                     exp_r.first_g, out_first_gesture);
          end
          if (out_second_gesture !== exp_r.second_g) begin
            fail_cnt++;
            $display("%0t: second_gesture expected %0d actual %0d", $time,
                     exp_r.second_g, out_second_gesture);
          end
          if (out_next_wait !== exp_r.next_wait) begin
            fail_cnt++;
            $display("%0t: next_wait expected %0d actual %0d", $time,
                     exp_r.next_wait, out_next_wait);
          end
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: random stalls, bursts of steady ready, one long hold
  initial begin : result_sink
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        stall = rx_burst ? 0 : $urandom_range(0, 19);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [1:0]  e1;
    logic [1:0]  e2;
    logic [31:0] t;

    // Directed rows under the reset settings (window 500, push 750, idle 65535)
    dir_rows.push_back('{EV_WAKE, EV_WAKE, 32'd100, 1, GEST_NONE, GEST_NONE, 16'd65535});
    dir_rows.push_back('{EV_UP,   EV_UP,   32'd200, 1, GEST_NONE, GEST_NONE, 16'd65535});
    // press at tick zero leaves nothing pending
    dir_rows.push_back('{EV_DOWN, EV_WAKE, 32'd0,   1, GEST_NONE, GEST_NONE, 16'd750});
    dir_rows.push_back('{EV_WAKE, EV_WAKE, 32'd10,  1, GEST_NONE, GEST_NONE, 16'd65535});
    dir_rows.push_back('{EV_UP,   EV_WAKE, 32'd20,  1, GEST_NONE, GEST_NONE, 16'd65535});
    // both bits: down wins
    dir_rows.push_back('{EV_BOTH, EV_BOTH, 32'd1000, 1, GEST_NONE, GEST_NONE, 16'd750});
    dir_rows.push_back('{EV_WAKE, EV_WAKE, 32'd1100, 1, GEST_NONE, GEST_NONE, 16'd650});
    dir_rows.push_back('{EV_UP,   EV_UP,   32'd1200, 1, GEST_NONE, GEST_NONE, 16'd300});
    dir_rows.push_back('{EV_WAKE, EV_WAKE, 32'd1400, 1, GEST_NONE, GEST_NONE, 16'd100});
    dir_rows.push_back('{EV_WAKE, EV_WAKE, 32'd1700, 1, GEST_CLICK, GEST_CLICK, 16'd65535});
    dir_rows.push_back('{EV_DOWN, EV_DOWN, 32'd2000, 1, GEST_NONE, GEST_NONE, 16'd750});
    dir_rows.push_back('{EV_UP,   EV_WAKE, 32'd2100, 1, GEST_NONE, GEST_NONE, 16'd400});
    dir_rows.push_back('{EV_DOWN, EV_WAKE, 32'd2300, 1, GEST_DOUBLE, GEST_NONE, 16'd450});
    // wake exactly at push time
    dir_rows.push_back('{EV_UP,   EV_WAKE, 32'd2750, 1, GEST_NONE, GEST_PUSH, 16'd65535});
    dir_rows.push_back('{EV_DOWN, EV_UP,   32'd3000, 1, GEST_NONE, GEST_NONE, 16'd750});
    dir_rows.push_back('{EV_UP,   EV_WAKE, 32'd3800, 1, GEST_PUSH, GEST_NONE, 16'd65535});
    dir_rows.push_back('{EV_DOWN, EV_WAKE, 32'd4000, 1, GEST_NONE, GEST_NONE, 16'd750});
    // release after the window but before push: wait is zero
    dir_rows.push_back('{EV_UP,   EV_WAKE, 32'd4600, 1, GEST_NONE, GEST_NONE, 16'd0});
    dir_rows.push_back('{EV_WAKE, EV_WAKE, 32'd4601, 1, GEST_CLICK, GEST_NONE, 16'd65535});
    // tick counter wrap, double click exactly at the window edge
    dir_rows.push_back('{EV_WAKE, EV_DOWN, 32'hFFFF_FF00, 1, GEST_NONE, GEST_NONE, 16'd750});
    dir_rows.push_back('{EV_WAKE, EV_UP,   32'h0000_0010, 1, GEST_NONE, GEST_NONE, 16'd228});
    dir_rows.push_back('{EV_WAKE, EV_DOWN, 32'h0000_00F4, 1, GEST_NONE, GEST_DOUBLE, 16'd65535});
    dir_rows.push_back('{EV_WAKE, EV_UP,   32'hFFFF_FFFF, 1, GEST_NONE, GEST_NONE, 16'd65535});
    dir_rows.push_back('{EV_DOWN, EV_DOWN, 32'h8000_0000, 0, GEST_NONE, GEST_NONE, 16'd0});
    dir_rows.push_back('{EV_BOTH, EV_WAKE, 32'h8000_01F4, 0, GEST_NONE, GEST_NONE, 16'd0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].first_ev, dir_rows[i].second_ev, dir_rows[i].now,
                dir_rows[i].has_exp,
                '{dir_rows[i].first_g, dir_rows[i].second_g, dir_rows[i].next_wait});
    drain_results();
    tick_now = 32'h8000_0200;

    // Random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      apply_setting(p);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 0 && k == 60) begin
          long_hold_req = 1'b1;
          tx_burst = 1'b1;
        end
        if (p == 2 && k == 100) drain_results();
        e1 = pick_event(0);
        e2 = pick_event(1);
        t  = next_tick();
        send_item(e1, e2, t, 1'b0, '0);
      end
      drain_results();
    end

    if (pending_results.size() != 0) begin
      fail_cnt++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    $display("Run covered %0d items (%0d directed) over %0d register settings,",
             items_sent, dir_rows.size(), PHASES);
    $display("with a %0d-cycle output hold and a full drain mid-stream; %0d errors.",
             LONG_HOLD, fail_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bgc_pkg.sv
rtl/bgc_lane.sv
rtl/button_gesture_classifier_unit.sv
tb/sv/tb_button_gesture_classifier_unit.sv
